// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers shared by the rtl, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked check, masked while reset is asserted
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKD(lbl, prop, msg)

`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- src/suv_pkg.sv -----
// ----------------------------------------------------------------------------
// suv_pkg
// types and constants of the strict utf-8 validator
// ----------------------------------------------------------------------------
package suv_pkg;

    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned AccumWidth = 21;
    localparam int unsigned FaultWidth = 3;

    localparam logic [AccumWidth-1:0] CpMax     = 21'h10FFFF;
    localparam logic [AccumWidth-1:0] SurrLow   = 21'h00D800;
    localparam logic [AccumWidth-1:0] SurrHigh  = 21'h00DFFF;
    localparam logic [AccumWidth-1:0] MinTwo    = 21'h000080;
    localparam logic [AccumWidth-1:0] MinThree  = 21'h000800;
    localparam logic [AccumWidth-1:0] MinFour   = 21'h010000;

    localparam logic [ByteWidth-1:0] CtrlLimit  = 8'h20;
    localparam logic [ByteWidth-1:0] DelByte    = 8'h7F;

    typedef enum logic [FaultWidth-1:0] {
        FK_NONE      = 3'd0,
        FK_CONTROL   = 3'd1,
        FK_BAD_LEAD  = 3'd2,
        FK_BAD_CONT  = 3'd3,
        FK_TRUNCATED = 3'd4,
        FK_OVERLONG  = 3'd5,
        FK_ABOVE     = 3'd6,
        FK_SURROGATE = 3'd7
    } fault_kind_t;

    typedef enum logic [1:0] {
        MC_NONE  = 2'd0,
        MC_TWO   = 2'd1,
        MC_THREE = 2'd2,
        MC_FOUR  = 2'd3
    } min_class_t;

    typedef struct packed {
        logic [1:0]            pending;
        logic [AccumWidth-1:0] accum;
        min_class_t            min_class;
        fault_kind_t           fault;
    } suv_state_t;

    localparam suv_state_t StateClear = '{
        pending:   2'd0,
        accum:     '0,
        min_class: MC_NONE,
        fault:     FK_NONE
    };

endpackage

// ----- src/suv_byte_if.sv -----
// ----------------------------------------------------------------------------
// suv_byte_if
// valid/ready channel carrying one text byte per request
// ----------------------------------------------------------------------------
interface suv_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink   (input valid, input text_byte, input is_final, output ready);

endinterface

// ----- src/suv_verdict_if.sv -----
// ----------------------------------------------------------------------------
// suv_verdict_if
// valid/ready channel carrying one verdict per request
// ----------------------------------------------------------------------------
interface suv_verdict_if;

    logic       valid;
    logic       ready;
    logic       text_ok;
    logic [2:0] fault_kind;

    modport source (output valid, output text_ok, output fault_kind, input ready);
    modport sink   (input valid, input text_ok, input fault_kind, output ready);

endinterface

// ----- src/suv_step.sv -----
// ----------------------------------------------------------------------------
// suv_step
// per-byte decode: next checker state and the verdict fault for a final byte
// ----------------------------------------------------------------------------
module suv_step (
    input  suv_pkg::suv_state_t  state,
    input  logic [7:0]           text_byte,
    input  logic                 is_final,
    output suv_pkg::suv_state_t  state_next,
    output suv_pkg::fault_kind_t verdict_fault
);

    import suv_pkg::*;

    logic [AccumWidth-1:0] acc_shift;
    logic [1:0]            pend_dec;
    logic [AccumWidth-1:0] cp_min;
    suv_state_t            work;

    assign acc_shift = {state.accum[AccumWidth-7:0], text_byte[5:0]};
    assign pend_dec  = state.pending - 2'd1;

    always_comb
    begin
        case (state.min_class)
            MC_THREE: cp_min = MinThree;
            MC_FOUR:  cp_min = MinFour;
            default:  cp_min = MinTwo;
        endcase
    end

    always_comb
    begin
        work = state;
        if (state.fault == FK_NONE)
        begin
            if (state.pending == 2'd0)
            begin
                if (!text_byte[7])
                begin
                    if (text_byte < CtrlLimit || text_byte == DelByte)
                        work.fault = FK_CONTROL;
                end
                else if (text_byte[7:5] == 3'b110)
                begin
                    work.pending   = 2'd1;
                    work.accum     = {16'd0, text_byte[4:0]};
                    work.min_class = MC_TWO;
                end
                else if (text_byte[7:4] == 4'b1110)
                begin
                    work.pending   = 2'd2;
                    work.accum     = {17'd0, text_byte[3:0]};
                    work.min_class = MC_THREE;
                end
                else if (text_byte[7:3] == 5'b11110)
                begin
                    work.pending   = 2'd3;
                    work.accum     = {18'd0, text_byte[2:0]};
                    work.min_class = MC_FOUR;
                end
                else
                begin
                    work.fault = FK_BAD_LEAD;
                end
            end
            else if (text_byte[7:6] != 2'b10)
            begin
                work.fault = FK_BAD_CONT;
            end
            else
            begin
                work.pending = pend_dec;
                work.accum   = acc_shift;
                if (pend_dec == 2'd0)
                begin
                    if (acc_shift < cp_min)
                        work.fault = FK_OVERLONG;
                    else if (acc_shift > CpMax)
                        work.fault = FK_ABOVE;
                    else if (acc_shift >= SurrLow && acc_shift <= SurrHigh)
                        work.fault = FK_SURROGATE;
                    work.accum     = '0;
                    work.min_class = MC_NONE;
                end
            end
        end
    end

    // sequence still open at end of text
    always_comb
    begin
        if (work.fault == FK_NONE && work.pending != 2'd0)
            verdict_fault = FK_TRUNCATED;
        else
            verdict_fault = work.fault;
    end

    assign state_next = is_final ? StateClear : work;

endmodule

// ----- src/strict_utf8_validator.sv -----
// ----------------------------------------------------------------------------
// strict_utf8_validator
// checks a byte stream against strict utf-8 and gives one verdict per text
// ----------------------------------------------------------------------------
//  channel   dir   payload                 requests
//  text      in    text_byte, is_final     one per byte
//  verdict   out   text_ok, fault_kind     one per text, on the final byte
//
//  one byte per cycle while text.ready is high; a byte is decoded against the
//  state register in the cycle it is taken, and the verdict sits in the output
//  register from the cycle after the final byte is taken
//  text.ready is low only while a verdict waits and verdict.ready is low
//  reset clears the decode state and empties the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strict_utf8_validator (
    input  logic          clk,
    input  logic          rst_n,
    suv_byte_if.sink      text,
    suv_verdict_if.source verdict
);

    import suv_pkg::*;

    suv_state_t  state_reg;
    suv_state_t  state_next;
    fault_kind_t step_fault;
    logic        out_valid_reg;
    logic        out_ok_reg;
    fault_kind_t out_fault_reg;
    logic        in_fire;
    logic        out_fire;

    suv_step u_step (
        .state         (state_reg),
        .text_byte     (text.text_byte),
        .is_final      (text.is_final),
        .state_next    (state_next),
        .verdict_fault (step_fault)
    );

    assign text.ready = !out_valid_reg || verdict.ready;
    assign in_fire    = text.valid && text.ready;
    assign out_fire   = verdict.valid && verdict.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= StateClear;
        else if (in_fire)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && text.is_final)
            out_valid_reg <= 1'b1;
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && text.is_final)
        begin
            out_ok_reg    <= (step_fault == FK_NONE);
            out_fault_reg <= step_fault;
        end
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.text_ok    = out_ok_reg;
    assign verdict.fault_kind = out_fault_reg;

    `ASSERT_CLKD(a_ok_matches_fault, verdict.valid |-> (verdict.text_ok == (verdict.fault_kind == FK_NONE)), "text_ok disagrees with fault_kind")
    `ASSERT_CLKD(a_final_gives_verdict, (in_fire && text.is_final) |=> verdict.valid, "final byte gave no verdict")
    `ASSERT_CLKD(a_final_clears_state, (in_fire && text.is_final) |=> (state_reg == StateClear), "state not cleared after final byte")
    `ASSERT_ALWAYS(a_open_has_class, (state_reg.pending != 2'd0) |-> (state_reg.min_class != MC_NONE), "open sequence without minimum class")
    `ASSERT_CLKD(a_fault_latched, (state_reg.fault != FK_NONE && !(in_fire && text.is_final)) |=> (state_reg.fault == $past(state_reg.fault)), "latched fault changed inside a text")

endmodule
